/* rtl/rmks_pkg.sv */
// Shared widths, register map and sort-mode codes for the record sorter.
`timescale 1ns / 1ps
package rmks_pkg;

	// Field widths of one record
	localparam int ID_W   = 16;
	localparam int DEST_W = 64;
	localparam int HOUR_W = 5;
	localparam int MIN_W  = 6;
	localparam int CHAR_W = 8;

	// Sort mode codes
	localparam logic SORT_BY_ID   = 1'b0;
	localparam logic SORT_BY_DEST = 1'b1;

	// Configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_SORT_MODE = 1'b0;

	// Queue between front and back; depth is a power of two so pointers wrap
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

endpackage

/* rtl/rmks_if.sv */
// Valid/ready channel interfaces for records in and sorted records out.
`timescale 1ns / 1ps
interface rmks_in_if;
	import rmks_pkg::*;
	logic              valid;
	logic              ready;
	logic [ID_W-1:0]   record_id;
	logic [DEST_W-1:0] destination;
	logic [HOUR_W-1:0] hour;
	logic [MIN_W-1:0]  minute;
	logic              last_record;

	modport source(output valid, record_id, destination, hour, minute, last_record,
		input ready);
	modport sink(input valid, record_id, destination, hour, minute, last_record,
		output ready);
endinterface

interface rmks_out_if;
	import rmks_pkg::*;
	logic              valid;
	logic              ready;
	logic [ID_W-1:0]   out_id;
	logic [DEST_W-1:0] out_destination;
	logic [HOUR_W-1:0] out_hour;
	logic [MIN_W-1:0]  out_minute;
	logic              out_last;
	logic              overflow;

	modport source(output valid, out_id, out_destination, out_hour, out_minute, out_last,
		overflow, input ready);
	modport sink(input valid, out_id, out_destination, out_hour, out_minute, out_last,
		overflow, output ready);
endinterface

/* rtl/rmks_front.sv */
// Front end: takes input items, trims the destination string and packs the record.
`timescale 1ns / 1ps
module rmks_front #(
	parameter int DEST_CHARS = 8
) (
	rmks_in_if.sink rec_in,
	output logic    push_valid,
	input  logic    push_ready,
	output logic [rmks_pkg::ID_W + rmks_pkg::CHAR_W*DEST_CHARS + rmks_pkg::HOUR_W
		+ rmks_pkg::MIN_W : 0] push_data
);
	import rmks_pkg::*;

	localparam int DW = CHAR_W * DEST_CHARS;

	logic [DEST_W-1:0] canon;

	// Keep the leading DEST_CHARS bytes and clear everything from the first NUL on
	function automatic logic [DEST_W-1:0] canon_dest(input logic [DEST_W-1:0] d);
		logic              alive;
		logic [DEST_W-1:0] r;
		logic [CHAR_W-1:0] ch;
		alive = 1'b1;
		r = '0;
		for (int b = 0; b < DEST_W / CHAR_W; b++) begin
			ch = d[DEST_W-1-CHAR_W*b -: CHAR_W];
			if (b >= DEST_CHARS || ch == '0) begin
				alive = 1'b0;
			end
			if (alive) begin
				r[DEST_W-1-CHAR_W*b -: CHAR_W] = ch;
			end
		end
		return r;
	endfunction

	assign canon = canon_dest(rec_in.destination);

	// Pass the handshake straight to the queue
	assign push_valid   = rec_in.valid;
	assign rec_in.ready = push_ready;
	assign push_data    = {rec_in.record_id, canon[DEST_W-1 -: DW], rec_in.hour,
		rec_in.minute, rec_in.last_record};

endmodule

/* rtl/rmks_queue.sv */
// Short first-in first-out queue between the front end and the sort engine.
`timescale 1ns / 1ps
module rmks_queue #(
	parameter int WIDTH = 92
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	import rmks_pkg::*;

	logic [WIDTH-1:0]   mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               push;
	logic               pop;

	assign push_ready = (cnt_q != Q_CNT_W'(Q_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Store the arriving item
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/rmks_back.sv */
// Sort engine: record store, odd-even transposition sort and output register.
`timescale 1ns / 1ps
module rmks_back #(
	parameter int MAX_RECORDS = 32,
	parameter int DEST_CHARS  = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic sort_mode,
	input  logic pop_valid,
	output logic pop_ready,
	input  logic [rmks_pkg::ID_W + rmks_pkg::CHAR_W*DEST_CHARS + rmks_pkg::HOUR_W
		+ rmks_pkg::MIN_W : 0] pop_data,
	rmks_out_if.source rec_out
);
	import rmks_pkg::*;

	localparam int DW    = CHAR_W * DEST_CHARS;
	localparam int KEY_W = DW + HOUR_W + MIN_W;
	localparam int CNT_W = $clog2(MAX_RECORDS + 1);

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_SORT = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  phase_q;
	logic [CNT_W-1:0]  rem_q;
	logic              parity_q;
	logic              drop_q;

	// Record store, one register per entry
	logic [ID_W-1:0]   id_q   [MAX_RECORDS];
	logic [DW-1:0]     dest_q [MAX_RECORDS];
	logic [HOUR_W-1:0] hour_q [MAX_RECORDS];
	logic [MIN_W-1:0]  min_q  [MAX_RECORDS];

	logic [ID_W-1:0]   p_id;
	logic [DW-1:0]     p_dest;
	logic [HOUR_W-1:0] p_hour;
	logic [MIN_W-1:0]  p_min;
	logic              p_last;

	logic              pop;
	logic              wr_en;
	logic              sorting;
	logic              adv;
	logic [MAX_RECORDS-1:0] sw;

	// Output register
	logic              out_valid_q;
	logic [ID_W-1:0]   out_id_q;
	logic [DW-1:0]     out_dest_q;
	logic [HOUR_W-1:0] out_hour_q;
	logic [MIN_W-1:0]  out_min_q;
	logic              out_last_q;
	logic              out_ovf_q;

	// True when record a must move behind record b
	function automatic logic after_f(input logic mode,
		input logic [ID_W-1:0] a_id, input logic [ID_W-1:0] b_id,
		input logic [KEY_W-1:0] a_key, input logic [KEY_W-1:0] b_key);
		logic res;
		case (mode)
			SORT_BY_ID:   res = (a_id > b_id);
			SORT_BY_DEST: res = (a_key > b_key);
			default:      res = 1'b0;
		endcase
		return res;
	endfunction

	assign {p_id, p_dest, p_hour, p_min, p_last} = pop_data;

	assign pop_ready = (state_q == ST_LOAD);
	assign pop       = pop_valid && pop_ready;
	assign wr_en     = pop && (count_q < CNT_W'(MAX_RECORDS));
	assign sorting   = (state_q == ST_SORT);
	assign adv       = (state_q == ST_EMIT) && (rem_q != '0)
		&& (!out_valid_q || rec_out.ready);

	// Compare fixed neighbor pairs of the current parity
	for (genvar k = 0; k < MAX_RECORDS - 1; k++) begin : g_pair
		assign sw[k] = sorting && (1'(k % 2) == parity_q) && (CNT_W'(k + 1) < count_q)
			&& after_f(sort_mode, id_q[k], id_q[k+1],
				{dest_q[k], hour_q[k], min_q[k]},
				{dest_q[k+1], hour_q[k+1], min_q[k+1]});
	end
	assign sw[MAX_RECORDS-1] = 1'b0;

	// Load, swap with a neighbor, or shift toward the head while emitting
	for (genvar k = 0; k < MAX_RECORDS; k++) begin : g_ent
		localparam int UP = (k == MAX_RECORDS - 1) ? k : k + 1;
		localparam int DN = (k == 0) ? 0 : k - 1;
		always_ff @(posedge clk) begin
			if (wr_en && count_q == CNT_W'(k)) begin
				id_q[k]   <= p_id;
				dest_q[k] <= p_dest;
				hour_q[k] <= p_hour;
				min_q[k]  <= p_min;
			end else if (sw[k] || adv) begin
				id_q[k]   <= id_q[UP];
				dest_q[k] <= dest_q[UP];
				hour_q[k] <= hour_q[UP];
				min_q[k]  <= min_q[UP];
			end else if (k != 0 && sw[DN]) begin
				id_q[k]   <= id_q[DN];
				dest_q[k] <= dest_q[DN];
				hour_q[k] <= hour_q[DN];
				min_q[k]  <= min_q[DN];
			end
		end
	end

	// Sequencer: load until the last record, sort count phases, then emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			count_q  <= '0;
			phase_q  <= '0;
			rem_q    <= '0;
			parity_q <= 1'b0;
			drop_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (pop) begin
						if (wr_en) begin
							count_q <= count_q + 1'b1;
						end else begin
							drop_q <= 1'b1;
						end
						if (p_last) begin
							state_q  <= ST_SORT;
							phase_q  <= '0;
							parity_q <= 1'b0;
						end
					end
				end
				ST_SORT: begin
					parity_q <= !parity_q;
					phase_q  <= phase_q + 1'b1;
					if (phase_q == CNT_W'(count_q - 1'b1)) begin
						state_q <= ST_EMIT;
						rem_q   <= count_q;
					end
				end
				ST_EMIT: begin
					if (adv) begin
						rem_q <= rem_q - 1'b1;
						if (rem_q == CNT_W'(1)) begin
							state_q <= ST_LOAD;
							count_q <= '0;
							drop_q  <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (rec_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_id_q   <= id_q[0];
			out_dest_q <= dest_q[0];
			out_hour_q <= hour_q[0];
			out_min_q  <= min_q[0];
			out_last_q <= (rem_q == CNT_W'(1));
			out_ovf_q  <= drop_q;
		end
	end

	assign rec_out.valid           = out_valid_q;
	assign rec_out.out_id          = out_id_q;
	assign rec_out.out_destination = DEST_W'(out_dest_q) << (DEST_W - DW);
	assign rec_out.out_hour        = out_hour_q;
	assign rec_out.out_minute      = out_min_q;
	assign rec_out.out_last        = out_last_q;
	assign rec_out.overflow        = out_ovf_q;

endmodule

/* rtl/record_multi_key_sorter_unit.sv */
// Top level of the record sorter: configuration register and the front/queue/back chain.
//
// Usage:
//   rec_in carries one record per item; last_record marks the final record of a
//   set. rec_out returns every kept record of the set, sorted stably, with
//   out_last on the final one and overflow on all of them if records were dropped.
//   sort_mode (APB byte address 0): 0 sorts by id, 1 by destination, hour, minute.
//   Records load one per cycle through a two-entry queue while the store loads.
//   After the last record the sort runs n phases for n kept records (one
//   odd-even transposition phase per cycle over all neighbor pairs of one parity
//   at once), then the results leave one per cycle from the output register
//   while the receiver keeps up.
//   Input stalls once the queue fills while the store sorts or emits.
//   Reset empties the store and the queue and clears sort_mode.
//   When the receiver stalls, the output register holds its item and emission
//   pauses; loading of the next set may proceed once the last result is taken
//   into the output register.
`timescale 1ns / 1ps
module record_multi_key_sorter_unit #(
	parameter int MAX_RECORDS = 32,
	parameter int DEST_CHARS  = 8
) (
	input  logic clk,
	input  logic arst_n,
	rmks_in_if.sink    rec_in,
	rmks_out_if.source rec_out,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [rmks_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [rmks_pkg::APB_DATA_W-1:0] pwdata,
	output logic [rmks_pkg::APB_DATA_W-1:0] prdata,
	output logic pready
);
	import rmks_pkg::*;

	localparam int REC_W = ID_W + CHAR_W * DEST_CHARS + HOUR_W + MIN_W + 1;

	logic             sort_mode_q;
	logic             sel_mode;
	logic             push_valid;
	logic             push_ready;
	logic [REC_W-1:0] push_data;
	logic             pop_valid;
	logic             pop_ready;
	logic [REC_W-1:0] pop_data;

	// Configuration register
	assign pready   = 1'b1;
	assign sel_mode = (paddr[APB_ADDR_W-1:2] == REG_SORT_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_mode_q <= SORT_BY_ID;
		end else if (psel && penable && pwrite && pready && sel_mode) begin
			sort_mode_q <= pwdata[0];
		end
	end

	assign prdata = sel_mode ? APB_DATA_W'(sort_mode_q) : '0;

	// Front end
	rmks_front #(
		.DEST_CHARS(DEST_CHARS)
	) u_front (
		.rec_in    (rec_in),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	// Queue
	rmks_queue #(
		.WIDTH(REC_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	// Sort engine
	rmks_back #(
		.MAX_RECORDS(MAX_RECORDS),
		.DEST_CHARS (DEST_CHARS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.sort_mode(sort_mode_q),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data (pop_data),
		.rec_out  (rec_out)
	);

endmodule

/* tb/tb_top.sv */
// Testbench for the record sorter: directed and random record sets checked against a sort predictor.
`timescale 1ns / 1ps
module tb_top;
	import rmks_pkg::*;

	localparam int STORE_DEPTH   = 32;
	localparam int DEST_LEN      = 8;
	localparam int QUIET_LIMIT   = 3000;
	localparam int SETTLE_CYCLES = 48;
	localparam int LONG_HOLD     = 400;
	localparam int PHASE_RECORDS = 90;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [DEST_W-1:0] dest;
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic              last;
	} record_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [DEST_W-1:0] dest;
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic              last;
		logic              overflow;
	} sorted_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	rmks_in_if  rec_in_bus();
	rmks_out_if rec_out_bus();

	record_t pending_recs[$];
	sorted_t sorted_q[$];
	record_t kept_recs[$];
	logic    dropped = 1'b0;
	logic    mode_shadow = SORT_BY_ID;
	bit      calm = 1'b0;
	int      errors = 0;

	record_t offered;
	int      gap_left;
	sorted_t want;
	int      stall_left;
	int      hold_left;
	bit      long_hold_done;
	int      result_count;
	int      quiet_cycles = 0;

	record_multi_key_sorter_unit #(
		.MAX_RECORDS(STORE_DEPTH),
		.DEST_CHARS(DEST_LEN)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.rec_in(rec_in_bus),
		.rec_out(rec_out_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Keep the top DEST_LEN characters and clear everything after the first zero byte
	function automatic logic [DEST_W-1:0] trim_dest(input logic [DEST_W-1:0] d);
		logic [DEST_W-1:0] res;
		bit ended;
		res = '0;
		ended = 1'b0;
		for (int b = 0; b < 8; b++) begin
			if (b >= DEST_LEN || d[63-8*b -: 8] == 8'h00)
				ended = 1'b1;
			if (!ended)
				res[63-8*b -: 8] = d[63-8*b -: 8];
		end
		return res;
	endfunction

	// True when record a must sit behind record b
	function automatic bit goes_after(input record_t a, input record_t b);
		if (mode_shadow == SORT_BY_ID)
			return a.id > b.id;
		if (a.dest != b.dest)
			return a.dest > b.dest;
		if (a.hour != b.hour)
			return a.hour > b.hour;
		return a.minute > b.minute;
	endfunction

	// Store one accepted record; on the last one sort stably and queue the sorted set
	function automatic void load_record(input record_t r);
		record_t kept;
		record_t key;
		sorted_t res;
		int j;
		if (kept_recs.size() < STORE_DEPTH) begin
			kept = r;
			kept.dest = trim_dest(r.dest);
			kept_recs.push_back(kept);
		end else begin
			dropped = 1'b1;
		end
		if (!r.last)
			return;
		for (int i = 1; i < kept_recs.size(); i++) begin
			key = kept_recs[i];
			j = i;
			while (j > 0 && goes_after(kept_recs[j-1], key)) begin
				kept_recs[j] = kept_recs[j-1];
				j--;
			end
			kept_recs[j] = key;
		end
		foreach (kept_recs[i]) begin
			res.id = kept_recs[i].id;
			res.dest = kept_recs[i].dest;
			res.hour = kept_recs[i].hour;
			res.minute = kept_recs[i].minute;
			res.last = (i == kept_recs.size() - 1);
			res.overflow = dropped;
			sorted_q.push_back(res);
		end
		kept_recs.delete();
		dropped = 1'b0;
	endfunction

	function automatic logic [DEST_W-1:0] pack_name(input string s);
		logic [DEST_W-1:0] d;
		d = '0;
		for (int k = 0; k < s.len() && k < 8; k++)
			d[63-8*k -: 8] = s[k];
		return d;
	endfunction

	function automatic void add_rec(input logic [ID_W-1:0] id, input logic [DEST_W-1:0] dest,
		input logic [HOUR_W-1:0] hour, input logic [MIN_W-1:0] minute, input logic last);
		record_t r;
		r.id = id;
		r.dest = dest;
		r.hour = hour;
		r.minute = minute;
		r.last = last;
		pending_recs.push_back(r);
	endfunction

	// Random record biased toward ties: ids often small or extreme, names often built from A, B and C
	function automatic record_t rand_record(input logic last);
		record_t r;
		int len;
		case ($urandom_range(0, 3))
			0: r.id = ID_W'($urandom_range(0, 7));
			1: r.id = $urandom_range(0, 1) ? '1 : '0;
			default: r.id = ID_W'($urandom);
		endcase
		r.dest = '0;
		if ($urandom_range(0, 5) == 0) begin
			r.dest = {$urandom, $urandom};
		end else begin
			len = $urandom_range(0, 8);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 1))
					r.dest[63-8*k -: 8] = 8'($urandom_range(8'h41, 8'h43));
				else
					r.dest[63-8*k -: 8] = 8'($urandom_range(1, 255));
			end
		end
		if ($urandom_range(0, 7) == 0)
			r.hour = HOUR_W'($urandom_range(0, 31));
		else
			r.hour = HOUR_W'($urandom_range(0, 23));
		if ($urandom_range(0, 7) == 0)
			r.minute = MIN_W'($urandom_range(0, 63));
		else
			r.minute = MIN_W'($urandom_range(0, 59));
		r.last = last;
		return r;
	endfunction

	// Queue whole sets: one of the given size, then mostly small ones
	task automatic queue_sets(input int first_size, input int total);
		int n;
		int size;
		size = first_size;
		n = 0;
		while (n < total) begin
			for (int k = 0; k < size; k++)
				pending_recs.push_back(rand_record(k == size - 1));
			n += size;
			case ($urandom_range(0, 9))
				0: size = $urandom_range(11, 31);
				1: size = $urandom_range(32, 36);
				default: size = $urandom_range(1, 10);
			endcase
		end
	endtask

	// Hold until every queued record is taken and every sorted record has come back
	task automatic wait_drain();
		do @(negedge clk);
		while (pending_recs.size() != 0 || rec_in_bus.valid || sorted_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write sort_mode over APB, then read it back
	task automatic set_sort_mode(input logic m);
		logic [APB_DATA_W-1:0] rd;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'(4 * REG_SORT_MODE);
		pwdata <= APB_DATA_W'(m);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		mode_shadow = m;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd !== APB_DATA_W'(m)) begin
			$error("sort_mode: expected %0h got %0h", m, rd);
			errors++;
		end
	endtask

	// Offer pending records, with random gaps between items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_in_bus.valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (rec_in_bus.valid && rec_in_bus.ready)
				load_record(offered);
			if (!rec_in_bus.valid || rec_in_bus.ready) begin
				if (gap_left > 0) begin
					rec_in_bus.valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (!calm && pending_recs.size() != 0 && $urandom_range(0, 9) == 0) begin
					rec_in_bus.valid <= 1'b0;
					gap_left <= $urandom_range(0, 8);
				end else if (pending_recs.size() != 0) begin
					offered = pending_recs.pop_front();
					rec_in_bus.valid <= 1'b1;
					rec_in_bus.record_id <= offered.id;
					rec_in_bus.destination <= offered.dest;
					rec_in_bus.hour <= offered.hour;
					rec_in_bus.minute <= offered.minute;
					rec_in_bus.last_record <= offered.last;
				end else begin
					rec_in_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Check sorted records and stall the output side at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_out_bus.ready <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
			long_hold_done <= 1'b0;
			result_count <= 0;
		end else begin
			if (rec_out_bus.valid && rec_out_bus.ready) begin
				result_count <= result_count + 1;
				if (sorted_q.size() == 0) begin
					$error("sorted item %0d arrived with nothing expected", result_count);
					errors++;
				end else begin
					want = sorted_q.pop_front();
					if (rec_out_bus.out_id !== want.id) begin
						$error("out_id: expected %0h got %0h", want.id, rec_out_bus.out_id);
						errors++;
					end
					if (rec_out_bus.out_destination !== want.dest) begin
						$error("out_destination: expected %0h got %0h", want.dest,
							rec_out_bus.out_destination);
						errors++;
					end
					if (rec_out_bus.out_hour !== want.hour) begin
						$error("out_hour: expected %0d got %0d", want.hour, rec_out_bus.out_hour);
						errors++;
					end
					if (rec_out_bus.out_minute !== want.minute) begin
						$error("out_minute: expected %0d got %0d", want.minute,
							rec_out_bus.out_minute);
						errors++;
					end
					if (rec_out_bus.out_last !== want.last) begin
						$error("out_last: expected %0b got %0b", want.last, rec_out_bus.out_last);
						errors++;
					end
					if (rec_out_bus.overflow !== want.overflow) begin
						$error("overflow: expected %0b got %0b", want.overflow,
							rec_out_bus.overflow);
						errors++;
					end
				end
			end
			// Once, hold off long enough for the store and queue to fill and block input
			if (hold_left > 0) begin
				rec_out_bus.ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (!long_hold_done && result_count >= 150 && rec_in_bus.valid) begin
				rec_out_bus.ready <= 1'b0;
				hold_left <= LONG_HOLD;
				long_hold_done <= 1'b1;
			end else if (stall_left > 0) begin
				rec_out_bus.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (!calm && $urandom_range(0, 6) == 0) begin
				rec_out_bus.ready <= 1'b0;
				stall_left <= $urandom_range(0, 8);
			end else begin
				rec_out_bus.ready <= 1'b1;
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rec_in_bus.valid && rec_in_bus.ready) || (rec_out_bus.valid && rec_out_bus.ready)
				|| (psel && penable))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rec_in_bus.valid = 1'b0;
		rec_in_bus.record_id = '0;
		rec_in_bus.destination = '0;
		rec_in_bus.hour = '0;
		rec_in_bus.minute = '0;
		rec_in_bus.last_record = 1'b0;
		rec_out_bus.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// By id: extremes, a tie that must keep load order, names cut at a zero byte
		set_sort_mode(SORT_BY_ID);
		add_rec('1, '1, 5'd31, 6'd63, 1'b0);
		add_rec('0, '0, 5'd0, 6'd0, 1'b0);
		add_rec(16'd300, 64'h4142_0043_0000_0000, 5'd23, 6'd59, 1'b0);
		add_rec(16'd300, pack_name("ZZ"), 5'd1, 6'd2, 1'b0);
		add_rec(16'd7, 64'h0041_4243_4445_4647, 5'd5, 6'd6, 1'b1);
		add_rec(16'd1234, pack_name("X"), 5'd12, 6'd34, 1'b1);
		wait_drain();

		// By destination, hour, minute: full ties, prefixes, out-of-range times, high characters
		set_sort_mode(SORT_BY_DEST);
		add_rec(16'd1, pack_name("PARIS"), 5'd10, 6'd30, 1'b0);
		add_rec(16'd2, pack_name("PARIS"), 5'd10, 6'd30, 1'b0);
		add_rec(16'd3, pack_name("PARIS"), 5'd10, 6'd5, 1'b0);
		add_rec(16'd4, pack_name("PARIS"), 5'd9, 6'd59, 1'b0);
		add_rec(16'd5, pack_name("PARI"), 5'd10, 6'd30, 1'b0);
		add_rec(16'd6, '1, 5'd31, 6'd63, 1'b0);
		add_rec(16'd7, '0, 5'd3, 6'd3, 1'b0);
		add_rec(16'd8, 64'h524F_4D45_0058_0000, 5'd0, 6'd0, 1'b0);
		add_rec(16'd9, pack_name("ROME"), 5'd24, 6'd60, 1'b0);
		add_rec(16'd10, 64'h8041_0000_0000_0000, 5'd17, 6'd45, 1'b1);
		wait_drain();

		// Random sets, alternating keys; each phase opens with a full or overflowing set
		set_sort_mode(SORT_BY_ID);
		queue_sets(33, PHASE_RECORDS);
		wait_drain();
		set_sort_mode(SORT_BY_DEST);
		queue_sets(32, PHASE_RECORDS);
		wait_drain();
		set_sort_mode(SORT_BY_ID);
		queue_sets(40, PHASE_RECORDS);
		wait_drain();
		set_sort_mode(SORT_BY_DEST);
		calm = 1'b1;
		queue_sets(35, PHASE_RECORDS);
		wait_drain();

		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
